@@ rtl/core/lcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared widths, register map, schedule codes and sequencer states of the
// loop chunk dispenser.
// ----------------------------------------------------------------------------
package lcd_pkg;

  // default loop index width
  localparam int unsigned INDEX_BITS_DEF = 48;

  // fixed field widths
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned CHUNK_W  = 24;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned WORKER_W = 9;
  localparam int unsigned DIVR_W   = STEP_W + WORKER_W;

  // register port
  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;
  localparam int unsigned REG_IDX_W = 3;

  // register indexes, one per 8-byte slot
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOOP_START   = 3'd0,
    REG_LOOP_BOUND   = 3'd1,
    REG_LOOP_STEP    = 3'd2,
    REG_OWNER_CHUNK  = 3'd3,
    REG_THIEF_CHUNK  = 3'd4,
    REG_OWNER_MODE   = 3'd5,
    REG_THIEF_MODE   = 3'd6,
    REG_WORKER_COUNT = 3'd7
  } lcd_reg_e;

  // schedule codes
  localparam logic [MODE_W-1:0] MODE_DYNAMIC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GUIDED  = 3'd2;

  // input op codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CHUNK,
    ST_MUL,
    ST_FIN
  } lcd_state_e;

endpackage

@@ rtl/core/loop_chunk_dispenser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_chunk_dispenser_top
// Hands out loop iteration chunks in dynamic or guided schedule.
// ----------------------------------------------------------------------------
// One item is worked at a time. A start beat gives no result. For a chunk
// request, the guided size and the clip test come from two bit-serial
// dividers running side by side, followed by a 16-step shift-add of chunk
// size times step magnitude. A request with an unsupported mode or a zero
// step skips the arithmetic and goes from setup straight to finishing. The
// result sits in an output register, so a new input beat is taken while the
// previous result is still stalled; the block waits only when a second
// result is ready before the first one left.
module loop_chunk_dispenser_top #(
  parameter int unsigned INDEX_BITS = lcd_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcd_pkg::APB_AW-1:0]    paddr,
  input  logic [lcd_pkg::APB_DW-1:0]    pwdata,
  output logic [lcd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic                          from_thief_i,
  input  logic                          collective_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [INDEX_BITS-1:0]  chunk_first_o,
  output logic signed [INDEX_BITS-1:0]  chunk_end_o,
  output logic                          run_o,
  output logic                          last_o,
  output logic                          error_o
);

  localparam int unsigned STEP_W   = lcd_pkg::STEP_W;
  localparam int unsigned CHUNK_W  = lcd_pkg::CHUNK_W;
  localparam int unsigned MODE_W   = lcd_pkg::MODE_W;
  localparam int unsigned WORKER_W = lcd_pkg::WORKER_W;
  localparam int unsigned DIVR_W   = lcd_pkg::DIVR_W;
  localparam int unsigned CNT_W    = $clog2(INDEX_BITS);
  localparam int unsigned CHK_W    = (INDEX_BITS > CHUNK_W) ? INDEX_BITS : CHUNK_W;

  // configuration registers
  logic [INDEX_BITS-1:0] loop_start_q, loop_bound_q;
  logic [STEP_W-1:0]     loop_step_q;
  logic [CHUNK_W-1:0]    owner_chunk_q, thief_chunk_q;
  logic [MODE_W-1:0]     owner_mode_q, thief_mode_q;
  logic [WORKER_W-1:0]   worker_count_q;

  logic                     cfg_wr;
  lcd_pkg::lcd_reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lcd_pkg::lcd_reg_e'(paddr[5:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_start_q   <= '0;
      loop_bound_q   <= '0;
      loop_step_q    <= STEP_W'(1);
      owner_chunk_q  <= CHUNK_W'(1);
      thief_chunk_q  <= CHUNK_W'(1);
      owner_mode_q   <= lcd_pkg::MODE_DYNAMIC;
      thief_mode_q   <= lcd_pkg::MODE_DYNAMIC;
      worker_count_q <= WORKER_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lcd_pkg::REG_LOOP_START:   loop_start_q   <= pwdata[INDEX_BITS-1:0];
        lcd_pkg::REG_LOOP_BOUND:   loop_bound_q   <= pwdata[INDEX_BITS-1:0];
        lcd_pkg::REG_LOOP_STEP:    loop_step_q    <= pwdata[STEP_W-1:0];
        lcd_pkg::REG_OWNER_CHUNK:  owner_chunk_q  <= pwdata[CHUNK_W-1:0];
        lcd_pkg::REG_THIEF_CHUNK:  thief_chunk_q  <= pwdata[CHUNK_W-1:0];
        lcd_pkg::REG_OWNER_MODE:   owner_mode_q   <= pwdata[MODE_W-1:0];
        lcd_pkg::REG_THIEF_MODE:   thief_mode_q   <= pwdata[MODE_W-1:0];
        lcd_pkg::REG_WORKER_COUNT: worker_count_q <= pwdata[WORKER_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lcd_pkg::REG_LOOP_START:   prdata = lcd_pkg::APB_DW'(loop_start_q);
      lcd_pkg::REG_LOOP_BOUND:   prdata = lcd_pkg::APB_DW'(loop_bound_q);
      lcd_pkg::REG_LOOP_STEP:    prdata = lcd_pkg::APB_DW'(loop_step_q);
      lcd_pkg::REG_OWNER_CHUNK:  prdata = lcd_pkg::APB_DW'(owner_chunk_q);
      lcd_pkg::REG_THIEF_CHUNK:  prdata = lcd_pkg::APB_DW'(thief_chunk_q);
      lcd_pkg::REG_OWNER_MODE:   prdata = lcd_pkg::APB_DW'(owner_mode_q);
      lcd_pkg::REG_THIEF_MODE:   prdata = lcd_pkg::APB_DW'(thief_mode_q);
      lcd_pkg::REG_WORKER_COUNT: prdata = lcd_pkg::APB_DW'(worker_count_q);
      default: ;
    endcase
  end

  // loop state and sequencer
  lcd_pkg::lcd_state_e   state_q, state_d;
  logic [INDEX_BITS-1:0] next_idx_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  thief_q;

  // per-request working registers
  logic                  err_q, guided_q, neg_q, before_q, over_q;
  logic [STEP_W-1:0]     mag_q;
  logic [CHUNK_W-1:0]    size_q;
  logic [CHK_W-1:0]      chunk_q;
  logic [INDEX_BITS-1:0] mcand_q, prod_q;
  logic [STEP_W-1:0]     mplier_q;

  // output register
  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] first_q, end_q;
  logic                  run_q, last_q, error_q;

  logic in_acc, out_take, fin_go;
  assign in_stall_o = (state_q != lcd_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign fin_go     = (state_q == lcd_pkg::ST_FIN) && (!out_valid_q || !out_stall_i);

  // request setup: schedule pick, distance, direction
  logic [MODE_W-1:0]     mode_sel;
  logic [CHUNK_W-1:0]    size_sel;
  logic [STEP_W-1:0]     mag;
  logic [WORKER_W-1:0]   wk;
  logic                  neg, cur_lt_ub, mode_err;
  logic [INDEX_BITS-1:0] span;
  logic [DIVR_W-1:0]     div_a;

  always_comb begin
    mode_sel  = thief_q ? thief_mode_q : owner_mode_q;
    size_sel  = thief_q ? thief_chunk_q : owner_chunk_q;
    if (size_sel == '0) begin
      size_sel = CHUNK_W'(1);
    end
    mode_err  = (mode_sel != lcd_pkg::MODE_DYNAMIC) && (mode_sel != lcd_pkg::MODE_GUIDED);
    neg       = loop_step_q[STEP_W-1];
    mag       = neg ? (~loop_step_q + STEP_W'(1)) : loop_step_q;
    wk        = (worker_count_q == '0) ? WORKER_W'(1) : worker_count_q;
    cur_lt_ub = $signed(next_idx_q) < $signed(loop_bound_q);
    span      = cur_lt_ub ? (loop_bound_q - next_idx_q) : (next_idx_q - loop_bound_q);
    div_a     = DIVR_W'(mag) * DIVR_W'(wk);
  end

  // two divider lanes: guided size and clip limit
  logic                  div_start, div_step;
  logic [INDEX_BITS-1:0] q_guided, q_limit;

  assign div_start = (state_q == lcd_pkg::ST_PREP);
  assign div_step  = (state_q == lcd_pkg::ST_DIV);

  lcd_div #(
    .DW (INDEX_BITS),
    .RW (DIVR_W)
  ) u_div_guided (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (span),
    .divisor_i  (div_a),
    .quot_o     (q_guided)
  );

  lcd_div #(
    .DW (INDEX_BITS),
    .RW (STEP_W)
  ) u_div_limit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (span),
    .divisor_i  (mag),
    .quot_o     (q_limit)
  );

  // chunk size after raise to the configured minimum
  logic [CHK_W-1:0] chunk_sel;
  always_comb begin
    chunk_sel = CHK_W'(size_q);
    if (guided_q && (CHK_W'(q_guided) > CHK_W'(size_q))) begin
      chunk_sel = CHK_W'(q_guided);
    end
  end

  // finishing: next index and result fields
  logic [INDEX_BITS-1:0] nxt;
  logic                  run_n, done_n, upd;
  always_comb begin
    nxt   = next_idx_q;
    run_n = 1'b0;
    done_n = done_q;
    upd   = 1'b0;
    if (!err_q && (mag_q != '0)) begin
      upd = 1'b1;
      if (!before_q || over_q) begin
        nxt = loop_bound_q;
      end else if (neg_q) begin
        nxt = next_idx_q - prod_q;
      end else begin
        nxt = next_idx_q + prod_q;
      end
      run_n = before_q;
      if (nxt == loop_bound_q) begin
        done_n = 1'b1;
      end
    end
  end

  // next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcd_pkg::ST_IDLE: begin
        if (in_acc && (op_i == lcd_pkg::OP_REQUEST)) begin
          state_d = lcd_pkg::ST_PREP;
        end
      end
      lcd_pkg::ST_PREP: begin
        if (mode_err || (mag == '0)) begin
          state_d = lcd_pkg::ST_FIN;
        end else begin
          state_d = lcd_pkg::ST_DIV;
        end
      end
      lcd_pkg::ST_DIV: begin
        if (cnt_q == CNT_W'(INDEX_BITS - 1)) begin
          state_d = lcd_pkg::ST_CHUNK;
        end
      end
      lcd_pkg::ST_CHUNK: state_d = lcd_pkg::ST_MUL;
      lcd_pkg::ST_MUL: begin
        if (cnt_q == CNT_W'(STEP_W - 1)) begin
          state_d = lcd_pkg::ST_FIN;
        end
      end
      lcd_pkg::ST_FIN: begin
        if (fin_go) begin
          state_d = lcd_pkg::ST_IDLE;
        end
      end
      default: state_d = lcd_pkg::ST_IDLE;
    endcase
  end

  // state register and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcd_pkg::ST_IDLE;
      next_idx_q <= '0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && (op_i == lcd_pkg::OP_START)) begin
        next_idx_q <= loop_start_q;
        done_q     <= 1'b0;
      end else if (fin_go && upd) begin
        next_idx_q <= nxt;
        done_q     <= done_n;
      end
      if ((state_q == lcd_pkg::ST_DIV) || (state_q == lcd_pkg::ST_MUL)) begin
        if (state_d != state_q) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      thief_q <= from_thief_i && !collective_i;
    end
    if (state_q == lcd_pkg::ST_PREP) begin
      err_q    <= mode_err;
      guided_q <= (mode_sel == lcd_pkg::MODE_GUIDED);
      neg_q    <= neg;
      mag_q    <= mag;
      size_q   <= size_sel;
      before_q <= neg ? ($signed(loop_bound_q) < $signed(next_idx_q)) : cur_lt_ub;
    end
    if (state_q == lcd_pkg::ST_CHUNK) begin
      chunk_q  <= chunk_sel;
      mcand_q  <= chunk_sel[INDEX_BITS-1:0];
      mplier_q <= mag_q;
      prod_q   <= '0;
    end
    // shift-add multiply, one step magnitude bit per cycle
    if (state_q == lcd_pkg::ST_MUL) begin
      over_q   <= chunk_q > CHK_W'(q_limit);
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[INDEX_BITS-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[STEP_W-1:1]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      first_q <= next_idx_q;
      end_q   <= nxt;
      run_q   <= run_n;
      last_q  <= done_n;
      error_q <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chunk_first_o = first_q;
  assign chunk_end_o   = end_q;
  assign run_o         = run_q;
  assign last_o        = last_q;
  assign error_o       = error_q;

endmodule

@@ rtl/core/lcd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_div
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module lcd_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned RW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          step_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  output logic [DW-1:0] quot_o
);

  logic [DW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dvs_q;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      if (!diff[RW]) begin
        rem_d = diff[RW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0;
      rem_q <= '0;
      dvs_q <= '0;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (start_i) begin
        dvs_q <= divisor_i;
      end
    end
  end

  assign quot_o = quo_q;

endmodule

@@ rtl/core/lcd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks of the loop chunk dispenser, bound to the top level.
// ----------------------------------------------------------------------------
module lcd_checker #(
  parameter int unsigned INDEX_BITS = lcd_pkg::INDEX_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  op_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [INDEX_BITS-1:0] chunk_first_o,
  input logic [INDEX_BITS-1:0] chunk_end_o,
  input logic                  run_o,
  input logic                  error_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chunk_first_o)
      && $stable(chunk_end_o) && $stable(run_o) && $stable(error_o))
    else $error("stalled result beat changed");

  // an error beat carries an empty chunk at the current index
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !run_o && (chunk_first_o == chunk_end_o))
    else $error("error beat with non-empty chunk");

  // a runnable chunk is never empty
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_o |-> (chunk_first_o != chunk_end_o))
    else $error("runnable chunk is empty");

  // a request keeps the input side busy while it is worked
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == lcd_pkg::OP_REQUEST) |=> in_stall_o)
    else $error("request accepted without going busy");

endmodule

bind loop_chunk_dispenser_top lcd_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_lcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .chunk_first_o (chunk_first_o),
  .chunk_end_o   (chunk_end_o),
  .run_o         (run_o),
  .error_o       (error_o)
);

@@ test/tb_loop_chunk_dispenser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_loop_chunk_dispenser_top
// Self-checking bench for the loop chunk dispenser. Loop settings go in over
// the register port while the block is quiet. Start and chunk-request beats
// come from a queue, and a local copy of the dispenser state predicts every
// chunk grant. A directed run covers extreme bounds, zero step, zero size,
// zero workers and bad modes. Randomly set-up loops then follow, under
// changing sender and receiver pacing.
// ----------------------------------------------------------------------------
module tb_loop_chunk_dispenser_top;

  localparam int IW          = lcd_pkg::INDEX_BITS_DEF;
  localparam int RAND_ITEMS  = 1650;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int QUIET_WAIT  = 100;

  localparam logic signed [IW-1:0] IDX_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [IW-1:0] IDX_MAX = {1'b0, {(IW-1){1'b1}}};

  // one input beat as queued for the driver
  typedef struct {
    logic op;
    logic thief;
    logic coll;
    logic drain;
  } loop_item_t;

  // one chunk grant as seen on the result channel
  typedef struct packed {
    logic [IW-1:0] first_idx;
    logic [IW-1:0] end_idx;
    logic          run;
    logic          last;
    logic          err;
  } chunk_grant_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [lcd_pkg::APB_AW-1:0]    paddr   = '0;
  logic [lcd_pkg::APB_DW-1:0]    pwdata  = '0;
  logic [lcd_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  op_i         = 1'b0;
  logic                  from_thief_i = 1'b0;
  logic                  collective_i = 1'b0;

  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic signed [IW-1:0]  chunk_first_o;
  logic signed [IW-1:0]  chunk_end_o;
  logic                  run_o;
  logic                  last_o;
  logic                  error_o;

  // mirrored loop settings
  logic signed [IW-1:0]  cfg_start     = '0;
  logic signed [IW-1:0]  cfg_bound     = '0;
  logic signed [15:0]    cfg_step      = 16'sd1;
  logic [23:0]           cfg_own_chunk = 24'd1;
  logic [23:0]           cfg_thf_chunk = 24'd1;
  logic [2:0]            cfg_own_mode  = lcd_pkg::MODE_DYNAMIC;
  logic [2:0]            cfg_thf_mode  = lcd_pkg::MODE_DYNAMIC;
  logic [8:0]            cfg_workers   = 9'd1;

  // mirrored dispenser state
  logic signed [IW-1:0]  next_idx  = '0;
  logic                  done_flag = 1'b0;

  loop_item_t            dispatch_q[$];
  chunk_grant_t          pending_grants[$];

  int                    idle_pct   = 0;
  int                    stall_pct  = 0;
  int                    mismatches = 0;
  int                    cycle_cnt  = 0;

  loop_chunk_dispenser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .from_thief_i  (from_thief_i),
    .collective_i  (collective_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .chunk_first_o (chunk_first_o),
    .chunk_end_o   (chunk_end_o),
    .run_o         (run_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // next grant from the mirrored state; returns 0 for a start beat
  function automatic bit grant_chunk(input logic op, input logic thief_req,
                                     input logic coll, output chunk_grant_t g);
    logic               thief;
    logic [2:0]         mode;
    logic [63:0]        size, mag, workers, chunk, span, q;
    logic signed [63:0] cur, ub, nxt;
    logic               neg, ahead, go;
    int                 s;
    g = '0;
    if (op == lcd_pkg::OP_START) begin
      next_idx  = cfg_start;
      done_flag = 1'b0;
      return 1'b0;
    end
    thief = thief_req && !coll;
    mode  = thief ? cfg_thf_mode : cfg_own_mode;
    size  = thief ? 64'(cfg_thf_chunk) : 64'(cfg_own_chunk);
    if (size == 0) size = 1;
    cur = next_idx;
    g.first_idx = next_idx;
    // unsupported schedule leaves the state alone
    if (mode != lcd_pkg::MODE_DYNAMIC && mode != lcd_pkg::MODE_GUIDED) begin
      g.end_idx = next_idx;
      g.last    = done_flag;
      g.err     = 1'b1;
      return 1'b1;
    end
    ub      = cfg_bound;
    s       = cfg_step;
    neg     = (s < 0);
    mag     = 64'(neg ? -s : s);
    workers = (cfg_workers == 0) ? 64'd1 : 64'(cfg_workers);
    span    = (cur < ub) ? 64'(ub - cur) : 64'(cur - ub);
    chunk   = size;
    go      = 1'b0;
    // guided size shrinks with the remaining distance
    if (mode == lcd_pkg::MODE_GUIDED && mag != 0) begin
      q = span / (mag * workers);
      if (q > chunk) chunk = q;
    end
    if (mag == 0) begin
      nxt = cur;
    end else begin
      ahead = neg ? (ub < cur) : (cur < ub);
      if (!ahead || chunk > span / mag) nxt = ub;
      else if (neg) nxt = cur - $signed(chunk * mag);
      else nxt = cur + $signed(chunk * mag);
      go = ahead;
      if (nxt == ub) done_flag = 1'b1;
    end
    next_idx  = nxt[IW-1:0];
    g.end_idx = nxt[IW-1:0];
    g.run     = go;
    g.last    = done_flag;
    return 1'b1;
  endfunction

  // input driver: takes beats from the dispatch queue, predicts on acceptance
  always @(posedge clk_i) begin : drive_beats
    logic         free;
    chunk_grant_t g;
    loop_item_t   it;
    free = !in_valid_i || !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (grant_chunk(op_i, from_thief_i, collective_i, g))
          pending_grants.push_back(g);
      end
      if (free) begin
        if (dispatch_q.size() != 0 && $urandom_range(99) >= idle_pct &&
            (!dispatch_q[0].drain || pending_grants.size() == 0)) begin
          it = dispatch_q.pop_front();
          in_valid_i   <= 1'b1;
          op_i         <= it.op;
          from_thief_i <= it.thief;
          collective_i <= it.coll;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : watch_grants
    chunk_grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected grant beat: first %0d end %0d", chunk_first_o, chunk_end_o);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        check_field("chunk_first", $signed(want.first_idx), chunk_first_o);
        check_field("chunk_end", $signed(want.end_idx), chunk_end_o);
        check_field("run", want.run, run_o);
        check_field("last", want.last, last_o);
        check_field("error", want.err, error_o);
      end
    end
  end

  task automatic push_item(input logic op, input logic thief, input logic coll,
                           input logic drain);
    loop_item_t it;
    it.op    = op;
    it.thief = thief;
    it.coll  = coll;
    it.drain = drain;
    dispatch_q.push_back(it);
  endtask

  // wait until every beat is taken, every grant is back and the block settles
  task automatic wait_quiet();
    while (dispatch_q.size() != 0 || in_valid_i || pending_grants.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_WAIT) @(posedge clk_i);
  endtask

  // one register write: setup cycle then access cycle
  task automatic reg_write(input lcd_pkg::lcd_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lcd_pkg::REG_LOOP_START:   cfg_start     = val[IW-1:0];
      lcd_pkg::REG_LOOP_BOUND:   cfg_bound     = val[IW-1:0];
      lcd_pkg::REG_LOOP_STEP:    cfg_step      = val[15:0];
      lcd_pkg::REG_OWNER_CHUNK:  cfg_own_chunk = val[23:0];
      lcd_pkg::REG_THIEF_CHUNK:  cfg_thf_chunk = val[23:0];
      lcd_pkg::REG_OWNER_MODE:   cfg_own_mode  = val[2:0];
      lcd_pkg::REG_THIEF_MODE:   cfg_thf_mode  = val[2:0];
      lcd_pkg::REG_WORKER_COUNT: cfg_workers   = val[8:0];
      default: ;
    endcase
  endtask

  task automatic program_loop(input logic signed [IW-1:0] st, input logic signed [IW-1:0] bd,
                              input logic signed [15:0] sp, input logic [23:0] oc,
                              input logic [23:0] tc, input logic [2:0] om,
                              input logic [2:0] tm, input logic [8:0] wk);
    reg_write(lcd_pkg::REG_LOOP_START, 64'($unsigned(st)));
    reg_write(lcd_pkg::REG_LOOP_BOUND, 64'($unsigned(bd)));
    reg_write(lcd_pkg::REG_LOOP_STEP, 64'($unsigned(sp)));
    reg_write(lcd_pkg::REG_OWNER_CHUNK, 64'(oc));
    reg_write(lcd_pkg::REG_THIEF_CHUNK, 64'(tc));
    reg_write(lcd_pkg::REG_OWNER_MODE, 64'(om));
    reg_write(lcd_pkg::REG_THIEF_MODE, 64'(tm));
    reg_write(lcd_pkg::REG_WORKER_COUNT, 64'(wk));
  endtask

  task automatic set_pace(input int pace);
    case (pace)
      1:       begin idle_pct = 67; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 67; end
      3:       begin idle_pct = 20; stall_pct = 20; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  function automatic logic [23:0] pick_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 24'($urandom_range(1, 12));
    if (r < 88) return 24'd0;
    if (r < 94) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 45) return lcd_pkg::MODE_DYNAMIC;
    if (r < 90) return lcd_pkg::MODE_GUIDED;
    return 3'($urandom_range(7));
  endfunction

  // stimulus and end of run
  initial begin
    int                   rand_items;
    int                   phase;
    int                   cnt;
    int                   r;
    int                   v;
    int                   n;
    logic signed [IW-1:0] st, bd;
    logic signed [15:0]   sp;
    logic [8:0]           wk;
    rand_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // request before any start, on reset settings
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    wait_quiet();

    // small forward loop, owner dynamic and thief guided
    program_loop(48'sd10, 48'sd20, 16'sd3, 24'd2, 24'd1, lcd_pkg::MODE_DYNAMIC,
                 lcd_pkg::MODE_GUIDED, 9'd2);
    push_item(lcd_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b1, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b1, 1'b0);
    // sender holds off until all grants are back
    push_item(lcd_pkg::OP_START, 1'b1, 1'b1, 1'b1);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
    wait_quiet();

    // full-range backward loop, zero size, zero workers, thief in a bad mode
    program_loop(IDX_MAX, IDX_MIN, 16'sh8000, 24'd0, 24'hFFFFFF, lcd_pkg::MODE_GUIDED,
                 3'd0, 9'd0);
    push_item(lcd_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b1, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    wait_quiet();

    // zero step, widest worker field
    program_loop(-48'sd5, 48'sd5, 16'sd0, 24'd4, 24'd1, lcd_pkg::MODE_GUIDED, 3'd7,
                 9'd511);
    push_item(lcd_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    // full-range forward loop, largest owner size
    program_loop(IDX_MIN, IDX_MAX, 16'sh7FFF, 24'hFFFFFF, 24'd1, lcd_pkg::MODE_DYNAMIC,
                 lcd_pkg::MODE_GUIDED, 9'd256);
    push_item(lcd_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
    push_item(lcd_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);

    // random loops, pacing rotates per phase
    for (phase = 0; rand_items < RAND_ITEMS; phase++) begin
      wait_quiet();
      set_pace(phase % 4);

      r = $urandom_range(99);
      if (r < 5) begin
        sp = 16'sd0;
      end else if (r < 15) begin
        case ($urandom_range(3))
          0:       sp = 16'sh8000;
          1:       sp = 16'sh7FFF;
          2:       sp = 16'sd1;
          default: sp = -16'sd1;
        endcase
      end else begin
        sp = 16'($urandom_range(1, 40));
        if ($urandom_range(1)) sp = -sp;
      end

      r = $urandom_range(99);
      if (r < 5) begin
        st = IDX_MIN;
      end else if (r < 10) begin
        st = IDX_MAX;
      end else if (r < 25) begin
        st = IW'({$urandom, $urandom});
      end else begin
        v  = $urandom_range(2000000);
        st = IW'(v - 1000000);
      end

      // mostly a whole number of steps away, sometimes anywhere
      r = $urandom_range(99);
      if (r < 70) begin
        n  = $urandom_range(120);
        bd = st + IW'(n * sp);
      end else if (r < 85) begin
        v  = $urandom_range(1000);
        bd = st + IW'(v - 500);
      end else if (r < 90) begin
        bd = IDX_MIN;
      end else if (r < 95) begin
        bd = IDX_MAX;
      end else begin
        bd = IW'({$urandom, $urandom});
      end

      r = $urandom_range(99);
      if (r < 80) wk = 9'($urandom_range(1, 8));
      else if (r < 85) wk = 9'd0;
      else if (r < 90) wk = 9'd256;
      else if (r < 95) wk = 9'd511;
      else wk = 9'($urandom_range(511));

      program_loop(st, bd, sp, pick_chunk(), pick_chunk(), pick_mode(), pick_mode(), wk);

      // mostly start-then-request runs, some stray beats
      cnt = 0;
      while (cnt < 70) begin
        if ($urandom_range(99) < 85) begin
          push_item(lcd_pkg::OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom_range(99) < 3);
          n = $urandom_range(1, 20);
          repeat (n) push_item(lcd_pkg::OP_REQUEST, 1'($urandom_range(1)),
                               1'($urandom_range(1)), 1'b0);
          cnt += n + 1;
        end else begin
          push_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
          cnt++;
        end
      end
      rand_items += cnt;
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
